[hw/rtl/name_keyed_hash_table_core_defines.svh]
// ---------------------------------------------------------------------------
// name keyed hash table: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NAME_KEYED_HASH_TABLE_CORE_DEFINES_SVH
`define NAME_KEYED_HASH_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define NKHT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NKHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/nkht_pkg.sv]
// ---------------------------------------------------------------------------
// nkht_pkg
// Constants, codes and state types of the name keyed hash table.
// ---------------------------------------------------------------------------
package nkht_pkg;

  // default geometry
  localparam int unsigned TableSlots = 127;
  localparam int unsigned ProbeStep  = 17;
  localparam int unsigned KeyBytes   = 32;
  localparam int unsigned ValueBits  = 64;

  // remainder reduction: bits of the hash consumed per cycle
  localparam int unsigned ModBitsPerStep = 4;
  localparam int unsigned ModSteps       = 32 / ModBitsPerStep;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  // hash unit states
  typedef enum logic [2:0] {
    H_IDLE,
    H_INIT,
    H_BLOCK,
    H_TAIL,
    H_FIN_A,
    H_FIN_B,
    H_MOD,
    H_DONE
  } hash_state_e;

  // table controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_EVAL
  } ctrl_state_e;

endpackage

[hw/rtl/nkht_ram.sv]
// ---------------------------------------------------------------------------
// nkht_ram
// Single port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
module nkht_ram #(
  parameter int unsigned Depth = 127,
  parameter int unsigned Width = 321,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wr_data_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/nkht_hash.sv]
// ---------------------------------------------------------------------------
// nkht_hash
// Sequential SuperFastHash over a normalised key, one four-byte block per
// cycle, followed by a radix-16 remainder by the slot count.
// ---------------------------------------------------------------------------
module nkht_hash #(
  parameter int unsigned TableSlots = nkht_pkg::TableSlots,
  parameter int unsigned KeyBytes   = nkht_pkg::KeyBytes,
  localparam int unsigned Nblk  = (KeyBytes + 3) / 4,
  localparam int unsigned LenW  = $clog2(KeyBytes + 1),
  localparam int unsigned SlotW = $clog2(TableSlots)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [Nblk*32-1:0] key_i,
  input  logic [LenW-1:0]   len_i,
  output logic              done_o,
  output logic [SlotW-1:0]  home_o
);

  localparam int unsigned BlkW = $clog2(Nblk + 1);
  localparam int unsigned RemW = SlotW + 1;
  localparam int unsigned CntW = $clog2(nkht_pkg::ModSteps);
  localparam logic [RemW-1:0] SlotsR = RemW'(TableSlots);
  localparam logic [CntW-1:0] LastCnt = CntW'(nkht_pkg::ModSteps - 1);

  nkht_pkg::hash_state_e state_q, state_d;
  logic [31:0]      h_q, h_d;
  logic [BlkW-1:0]  blk_q, blk_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SlotW-1:0] rem_q, rem_d;

  logic [31:0]     words [Nblk+1];
  logic [LenW-1:0] blk_full;
  logic [BlkW-1:0] blocks;
  logic [1:0]      tail;

  // block view of the key, with a zero word past the end
  always_comb begin
    for (int i = 0; i < Nblk; i++) begin
      words[i] = key_i[32*i +: 32];
    end
    words[Nblk] = 32'd0;
  end

  assign blk_full = len_i >> 2;
  assign blocks   = blk_full[BlkW-1:0];
  assign tail     = len_i[1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nkht_pkg::H_IDLE:  if (start_i) state_d = nkht_pkg::H_INIT;
      nkht_pkg::H_INIT:  state_d = (blocks == '0) ? nkht_pkg::H_TAIL : nkht_pkg::H_BLOCK;
      nkht_pkg::H_BLOCK: if (blk_q + 1'b1 == blocks) state_d = nkht_pkg::H_TAIL;
      nkht_pkg::H_TAIL:  state_d = nkht_pkg::H_FIN_A;
      nkht_pkg::H_FIN_A: state_d = nkht_pkg::H_FIN_B;
      nkht_pkg::H_FIN_B: state_d = nkht_pkg::H_MOD;
      nkht_pkg::H_MOD:   if (cnt_q == LastCnt) state_d = nkht_pkg::H_DONE;
      nkht_pkg::H_DONE:  state_d = nkht_pkg::H_IDLE;
      default:           state_d = nkht_pkg::H_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic [31:0]     w;
    logic [31:0]     a;
    logic [31:0]     b;
    logic [RemW-1:0] r;
    w     = words[blk_q];
    a     = 32'd0;
    b     = 32'd0;
    r     = '0;
    h_d   = h_q;
    blk_d = blk_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    case (state_q)
      nkht_pkg::H_INIT: begin
        h_d   = 32'(len_i);
        blk_d = '0;
      end
      nkht_pkg::H_BLOCK: begin
        a     = h_q + {16'd0, w[15:0]};
        b     = (a << 16) ^ (({16'd0, w[31:16]} << 11) ^ a);
        h_d   = b + (b >> 11);
        blk_d = blk_q + 1'b1;
      end
      nkht_pkg::H_TAIL: begin
        case (tail)
          2'd3: begin
            a   = h_q + {16'd0, w[15:0]};
            a   = a ^ (a << 16);
            a   = a ^ ({{24{w[23]}}, w[23:16]} << 18);
            h_d = a + (a >> 11);
          end
          2'd2: begin
            a   = h_q + {16'd0, w[15:0]};
            a   = a ^ (a << 11);
            h_d = a + (a >> 17);
          end
          2'd1: begin
            a   = h_q + {{24{w[7]}}, w[7:0]};
            a   = a ^ (a << 10);
            h_d = a + (a >> 1);
          end
          default: h_d = h_q;
        endcase
      end
      nkht_pkg::H_FIN_A: begin
        a   = h_q ^ (h_q << 3);
        a   = a + (a >> 5);
        h_d = a ^ (a << 4);
        cnt_d = '0;
        rem_d = '0;
      end
      nkht_pkg::H_FIN_B: begin
        a   = h_q + (h_q >> 17);
        a   = a ^ (a << 25);
        h_d = a + (a >> 6);
      end
      nkht_pkg::H_MOD: begin
        r = RemW'(rem_q);
        for (int k = 0; k < nkht_pkg::ModBitsPerStep; k++) begin
          r = {r[RemW-2:0], h_q[31-k]};
          if (r >= SlotsR) r = r - SlotsR;
        end
        rem_d = r[SlotW-1:0];
        h_d   = h_q << nkht_pkg::ModBitsPerStep;
        cnt_d = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nkht_pkg::H_IDLE;
      cnt_q   <= '0;
      blk_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      blk_q   <= blk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    rem_q <= rem_d;
  end

  // outputs
  always_comb begin
    done_o = (state_q == nkht_pkg::H_DONE);
    home_o = rem_q;
  end

endmodule

[hw/rtl/name_keyed_hash_table_core.sv]
// ---------------------------------------------------------------------------
// name_keyed_hash_table_core
// Open addressing hash table keyed by names of up to KeyBytes bytes.
// ---------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. It is an
// insert (operation 0) or a search (operation 1) on the key words, which are
// cut at the first zero byte. One result per request appears on status_o,
// found_value_o and slot_index_o for exactly one cycle, marked by
// result_valid_o; the receiver cannot stall it.
// A request is hashed over Kb, the number of whole four-byte blocks in the
// key (0 to 8), and the tail, then the slot RAM is probed, and the result
// is registered. The hash remainder is taken at four bits a cycle, and
// each probe is one read of the slot RAM followed by a compare. One
// request is in flight at a time; busy drops in the cycle the result is
// shown, so a new request may start in that cycle.
// After reset the block sweeps the slot RAM to clear the used flags, one
// slot a cycle, holding busy high meanwhile.
// ---------------------------------------------------------------------------
`include "name_keyed_hash_table_core_defines.svh"

module name_keyed_hash_table_core #(
  parameter int unsigned TableSlots = nkht_pkg::TableSlots,
  parameter int unsigned ProbeStep  = nkht_pkg::ProbeStep,
  parameter int unsigned KeyBytes   = nkht_pkg::KeyBytes,
  parameter int unsigned ValueBits  = nkht_pkg::ValueBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [63:0] key_word0_i,
  input  logic [63:0] key_word1_i,
  input  logic [63:0] key_word2_i,
  input  logic [63:0] key_word3_i,
  input  logic [63:0] entry_value_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [63:0] found_value_o,
  output logic [6:0]  slot_index_o
);

  localparam int unsigned KeyBits = KeyBytes * 8;
  localparam int unsigned Nblk    = (KeyBytes + 3) / 4;
  localparam int unsigned LenW    = $clog2(KeyBytes + 1);
  localparam int unsigned SlotW   = $clog2(TableSlots);
  localparam int unsigned RowW    = 1 + KeyBits + ValueBits;
  localparam logic [SlotW:0]   SlotsX = (SlotW + 1)'(TableSlots);
  localparam logic [SlotW:0]   StepX  = (SlotW + 1)'(ProbeStep);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TableSlots - 1);

  nkht_pkg::ctrl_state_e state_q, state_d;

  logic               op_q;
  logic [KeyBits-1:0] key_q;
  logic [LenW-1:0]    len_q;
  logic [ValueBits-1:0] value_q;
  logic [SlotW-1:0]   clr_q, clr_d;
  logic [SlotW-1:0]   idx_q, idx_d;
  logic [SlotW-1:0]   home_q, home_d;
  logic               first_q, first_d;
  logic               rvalid_q, rvalid_d;
  logic [1:0]         status_q, status_d;
  logic [63:0]        found_q, found_d;
  logic [6:0]         slot_q, slot_d;

  logic               accept;
  logic [255:0]       raw_key;
  logic [KeyBytes-1:0] keep;
  logic [KeyBits-1:0] norm_key;

  logic               hash_done;
  logic [SlotW-1:0]   hash_home;

  logic               ram_wr, ram_rd;
  logic [SlotW-1:0]   ram_addr;
  logic [RowW-1:0]    ram_wdata, ram_rdata;

  logic               row_used, row_match;
  logic [KeyBits-1:0] row_key;
  logic [ValueBits-1:0] row_val;
  logic [SlotW:0]     nxt_x;
  logic [SlotW-1:0]   nxt;
  logic               hit, stop;

  assign accept  = start && !busy;
  assign raw_key = {key_word3_i, key_word2_i, key_word1_i, key_word0_i};

  // key normalisation: keep bytes before the first zero
  always_comb begin
    for (int i = 0; i < KeyBytes; i++) begin
      if (i == 0) keep[i] = (raw_key[7:0] != 8'd0);
      else        keep[i] = keep[i-1] && (raw_key[8*i +: 8] != 8'd0);
      norm_key[8*i +: 8] = keep[i] ? raw_key[8*i +: 8] : 8'd0;
    end
  end

  // request registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      key_q   <= norm_key;
      len_q   <= LenW'($countones(keep));
      value_q <= entry_value_i[ValueBits-1:0];
    end
  end

  // hash unit
  nkht_hash #(
    .TableSlots(TableSlots),
    .KeyBytes  (KeyBytes)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .key_i  ((Nblk*32)'(key_q)),
    .len_i  (len_q),
    .done_o (hash_done),
    .home_o (hash_home)
  );

  // slot RAM: used flag, key and value per row
  nkht_ram #(
    .Depth(TableSlots),
    .Width(RowW),
    .AddrW(SlotW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_wr),
    .rd_en_i  (ram_rd),
    .addr_i   (ram_addr),
    .wr_data_i(ram_wdata),
    .rd_data_o(ram_rdata)
  );

  // row decode and probe arithmetic
  assign row_used  = ram_rdata[RowW-1];
  assign row_key   = ram_rdata[ValueBits +: KeyBits];
  assign row_val   = ram_rdata[ValueBits-1:0];
  assign row_match = (row_key == key_q);
  assign nxt_x     = {1'b0, idx_q} + StepX;
  assign nxt       = (nxt_x >= SlotsX) ? SlotW'(nxt_x - SlotsX) : nxt_x[SlotW-1:0];
  assign hit       = (op_q == nkht_pkg::OP_SEARCH) ? (row_used && row_match)
                                                   : (!row_used || row_match);
  assign stop      = (op_q == nkht_pkg::OP_SEARCH) && !first_q && !row_used;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nkht_pkg::ST_CLEAR: if (clr_q == LastSlot) state_d = nkht_pkg::ST_IDLE;
      nkht_pkg::ST_IDLE:  if (start) state_d = nkht_pkg::ST_HASH;
      nkht_pkg::ST_HASH:  if (hash_done) state_d = nkht_pkg::ST_READ;
      nkht_pkg::ST_READ:  state_d = nkht_pkg::ST_EVAL;
      nkht_pkg::ST_EVAL: begin
        if (stop || hit || nxt == home_q) state_d = nkht_pkg::ST_IDLE;
        else                              state_d = nkht_pkg::ST_READ;
      end
      default: state_d = nkht_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    busy      = (state_q != nkht_pkg::ST_IDLE);
    clr_d     = clr_q;
    idx_d     = idx_q;
    home_d    = home_q;
    first_d   = first_q;
    rvalid_d  = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    slot_d    = slot_q;
    ram_wr    = 1'b0;
    ram_rd    = 1'b0;
    ram_addr  = idx_q;
    ram_wdata = {1'b1, key_q, value_q};
    case (state_q)
      nkht_pkg::ST_CLEAR: begin
        ram_wr    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      nkht_pkg::ST_HASH: begin
        idx_d   = hash_home;
        home_d  = hash_home;
        first_d = 1'b1;
      end
      nkht_pkg::ST_READ: begin
        ram_rd = 1'b1;
      end
      nkht_pkg::ST_EVAL: begin
        first_d = 1'b0;
        idx_d   = nxt;
        if (!stop && hit) begin
          rvalid_d = 1'b1;
          status_d = nkht_pkg::STATUS_OK;
          slot_d   = 7'(idx_q);
          if (op_q == nkht_pkg::OP_SEARCH) begin
            found_d = 64'(row_val);
          end else begin
            found_d = 64'd0;
            ram_wr  = 1'b1;
          end
        end else if (stop || nxt == home_q) begin
          rvalid_d = 1'b1;
          status_d = (op_q == nkht_pkg::OP_SEARCH) ? nkht_pkg::STATUS_NOTFOUND
                                                   : nkht_pkg::STATUS_FULL;
          found_d  = 64'd0;
          slot_d   = 7'd0;
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nkht_pkg::ST_CLEAR;
      clr_q    <= '0;
      rvalid_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      rvalid_q <= rvalid_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    home_q   <= home_d;
    status_q <= status_d;
    found_q  <= found_d;
    slot_q   <= slot_d;
  end

  assign result_valid_o = rvalid_q;
  assign status_o       = status_q;
  assign found_value_o  = found_q;
  assign slot_index_o   = slot_q;

  // checks
  `NKHT_ASSERT_NEXT(a_single_result, result_valid_o, !result_valid_o, "result strobe repeated")
  `NKHT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised after request")
  `NKHT_ASSERT_SAME(a_miss_zeroes, result_valid_o && status_o != nkht_pkg::STATUS_OK,
                    slot_index_o == 7'd0 && found_value_o == 64'd0, "miss fields not zero")
  `NKHT_ASSERT_SAME(a_result_idle, result_valid_o, !busy, "result shown while busy")

endmodule
